// ===== rtl/kcs_pkg.sv =====
// Package for the keyframe curve sampler: sizes, register indexes, sequencer states.
// Used by kcs_divider, keyframe_curve_sampler, kcs_checker and the testbench; depends on nothing.
`timescale 1ns / 1ps
package kcs_pkg;
	localparam int MaxKeys = 64;
	localparam int IdxW = $clog2(MaxKeys);
	localparam int CountW = IdxW + 1;

	typedef enum logic [1:0] {
		REG_KEY_COUNT   = 2'd0,
		REG_LOOP_ENABLE = 2'd1,
		REG_LOOP_LENGTH = 2'd2
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRAP,
		ST_WRAP_WAIT,
		ST_HINT_RD,
		ST_HINT_CMP,
		ST_BS_CHECK,
		ST_BS_RD,
		ST_BS_CMP,
		ST_SEG_RD,
		ST_SEG_LATCH,
		ST_FRAC_WAIT,
		ST_MUL,
		ST_CLAMP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

// ===== rtl/keyframe_curve_sampler.sv =====
// Keyframe curve sampler: piecewise linear interpolation over a keyframe table.
// A sample uses the shared serial divider at most once, twice with looping (the wrap and
// the fraction); a binary search of up to six probes follows a miss of the segment hint.
// One item at a time: in_ready is low while a sample is worked on or its result waits.
// Reset clears configuration, the segment hint and the sequencer; tables are undefined.
`timescale 1ns / 1ps
module keyframe_curve_sampler
	import kcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [5:0]         key_index,
	input  logic [31:0]        key_time,
	input  logic signed [31:0] key_value,
	input  logic [31:0]        sample_time,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] sample_value,
	output logic [5:0]         segment_used,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	// Configuration registers.
	logic [6:0]  key_count_q;
	logic        loop_enable_q;
	logic [31:0] loop_length_q;

	// Key tables: one write port, one registered read port each; value_mem also reads entry 0 directly.
	logic [31:0] time_mem [MaxKeys];
	logic [31:0] value_mem [MaxKeys];
	logic [IdxW-1:0] rd_addr;
	logic [31:0] rd_time_q;
	logic [31:0] rd_value_q;

	state_t state_q, state_d;

	// Sequencer working registers.
	logic [IdxW-1:0]   hint_q;
	logic [31:0]       tw_q;
	logic [CountW-1:0] n_q;
	logic signed [CountW:0] lo_q, hi_q, mid_q;
	logic [IdxW-1:0]   seg_q;
	logic              probe_hi_q;   // second read of a probe pair pending
	logic [31:0]       t0_q;
	logic signed [31:0] v0_q;
	logic              found_q;
	logic signed [32:0] diff_q;
	logic signed [32:0] frac_q;
	logic              frac_neg_q;   // sample time lies before the segment start
	logic signed [66:0] prod_q;
	logic signed [31:0] result_q;
	logic [IdxW-1:0]   seg_out_q;
	logic              out_valid_q;

	// Shared divider.
	logic        div_start;
	logic [63:0] div_dividend;
	logic [32:0] div_divisor;
	div_ctl_t    div_ctl;
	logic [63:0] div_quo;
	logic [32:0] div_rem;

	kcs_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.ctl      (div_ctl),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	logic accept_in;
	logic [CountW-1:0] n_eff;
	logic signed [CountW:0] top;
	logic [IdxW-1:0] hint_clip;
	logic probe_hit;

	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign accept_in = in_valid && in_ready;
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign sample_value = result_q;
	assign segment_used = seg_out_q;

	// A count above the table size acts as the table size.
	assign n_eff = (key_count_q > 7'(MaxKeys)) ? CountW'(MaxKeys) : CountW'(key_count_q);
	assign top   = $signed({1'b0, n_q}) - (CountW+1)'(2);
	assign hint_clip = ($signed({{(CountW+1-IdxW){1'b0}}, hint_q}) > top)
		? IdxW'(top) : hint_q;
	// A probe hits when t[k] <= tw (first read) and tw <= t[k+1] (second read).
	assign probe_hit = found_q && (tw_q <= rd_time_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q   <= '0;
			loop_enable_q <= 1'b0;
			loop_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEY_COUNT:   key_count_q   <= cfg_data[6:0];
				REG_LOOP_ENABLE: loop_enable_q <= cfg_data[0];
				REG_LOOP_LENGTH: loop_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in && !action) begin
			time_mem[key_index]  <= key_time;
			value_mem[key_index] <= key_value;
		end
		rd_time_q  <= time_mem[rd_addr];
		rd_value_q <= value_mem[rd_addr];
	end

	// Read address: the sequencer picks the entry it probes. The hint probe
	// reads its first entry before seg_q holds the hint.
	always_comb begin
		rd_addr = seg_q;
		if (state_q == ST_HINT_RD) rd_addr = hint_clip;
		else if (probe_hi_q) rd_addr = seg_q + IdxW'(1);
	end

	// Divider operands: the wrap uses tw / length, the fraction |tw - t0| * 65536 / span.
	logic [32:0] frac_num;
	logic [31:0] frac_mag;
	assign frac_num = {1'b0, tw_q} - {1'b0, t0_q};
	assign frac_mag = frac_num[32] ? 32'(33'd0 - frac_num) : frac_num[31:0];
	always_comb begin
		div_start    = 1'b0;
		div_dividend = {32'd0, tw_q};
		div_divisor  = {1'b0, loop_length_q};
		if (state_q == ST_WRAP) div_start = 1'b1;
		if (state_q == ST_SEG_LATCH && !probe_hi_q && found_q) begin
			div_start    = ($signed({1'b0, rd_time_q}) - $signed({1'b0, t0_q})) > 0;
			div_dividend = {16'd0, frac_mag, 16'd0};
			div_divisor  = {1'b0, rd_time_q} - {1'b0, t0_q};
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept_in && action) begin
				if (n_eff < CountW'(2)) state_d = ST_OUT;
				else if (loop_enable_q && loop_length_q != 0) state_d = ST_WRAP;
				else state_d = ST_HINT_RD;
			end
			ST_WRAP:      state_d = ST_WRAP_WAIT;
			ST_WRAP_WAIT: if (div_ctl.done) state_d = ST_HINT_RD;
			ST_HINT_RD:   state_d = ST_HINT_CMP;
			ST_HINT_CMP:  if (!probe_hi_q) state_d = probe_hit ? ST_SEG_RD : ST_BS_CHECK;
			ST_BS_CHECK:  state_d = (lo_q <= hi_q) ? ST_BS_RD : ST_SEG_RD;
			ST_BS_RD:     state_d = ST_BS_CMP;
			ST_BS_CMP:    if (!probe_hi_q) state_d = probe_hit ? ST_SEG_RD : ST_BS_CHECK;
			ST_SEG_RD:    state_d = ST_SEG_LATCH;
			ST_SEG_LATCH: if (!probe_hi_q) state_d = div_start ? ST_FRAC_WAIT : ST_OUT;
			ST_FRAC_WAIT: if (div_ctl.done) state_d = ST_MUL;
			ST_MUL:       state_d = ST_CLAMP;
			ST_CLAMP:     state_d = ST_OUT;
			ST_OUT:       state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hint_q      <= '0;
			out_valid_q <= 1'b0;
			probe_hi_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (state_q == ST_OUT) out_valid_q <= 1'b1;
			// Each probe reads two entries in turn: t[k] then t[k+1].
			unique case (state_q)
				ST_HINT_RD, ST_BS_RD, ST_SEG_RD: probe_hi_q <= 1'b1;
				ST_HINT_CMP, ST_BS_CMP, ST_SEG_LATCH: probe_hi_q <= 1'b0;
				default: ;
			endcase
			if (state_q == ST_SEG_LATCH && !probe_hi_q) hint_q <= seg_q;
		end
	end

	// Fraction floored and saturated to the signed 32-bit range; it is negative
	// when the sample time lies before the segment start.
	logic signed [32:0] frac_sat;
	logic [32:0] neg_mag;
	assign neg_mag = {1'b0, div_quo[31:0]} + {32'd0, (div_rem != '0)};
	always_comb begin
		if (!frac_neg_q)
			frac_sat = (div_quo > 64'h7FFF_FFFF) ? 33'sh0_7FFF_FFFF
				: $signed({1'b0, div_quo[31:0]});
		else if (div_quo >= 64'h8000_0000)
			frac_sat = -33'sh0_8000_0000;
		else
			frac_sat = $signed(33'd0 - neg_mag);
	end
	logic signed [66:0] vsum;
	assign vsum = $signed({{35{v0_q[31]}}, v0_q}) + (prod_q >>> 16);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (accept_in && action) begin
				n_q      <= n_eff;
				tw_q     <= sample_time;
				seg_out_q <= '0;
				result_q <= (n_eff == '0) ? 32'sd0 : value_mem[0];
			end
			ST_WRAP_WAIT: if (div_ctl.done) tw_q <= div_rem[31:0];
			ST_HINT_RD: seg_q <= hint_clip;
			ST_HINT_CMP, ST_BS_CMP: if (probe_hi_q) begin
				// First read of the pair: t[k] <= tw.
				found_q <= rd_time_q <= tw_q;
			end else begin
				if (probe_hit) begin
					found_q <= 1'b1;
				end else begin
					if (state_q == ST_HINT_CMP) begin
						lo_q <= '0;
						hi_q <= top;
					end else if (found_q) begin
						lo_q <= mid_q + (CountW+1)'(1);
					end else begin
						hi_q <= mid_q - (CountW+1)'(1);
					end
					found_q <= 1'b0;
				end
			end
			ST_BS_CHECK: begin
				mid_q <= (lo_q + hi_q) >>> 1;
				seg_q <= IdxW'((lo_q + hi_q) >>> 1);
				if (lo_q > hi_q) begin
					seg_q   <= (lo_q > top) ? IdxW'(top) : IdxW'(lo_q);
					found_q <= 1'b1;
				end
			end
			ST_SEG_RD: found_q <= 1'b1;
			ST_SEG_LATCH: if (probe_hi_q) begin
				t0_q <= rd_time_q;
				v0_q <= rd_value_q;
			end else begin
				diff_q     <= $signed({rd_value_q[31], rd_value_q}) - $signed({v0_q[31], v0_q});
				frac_neg_q <= frac_num[32];
				seg_out_q  <= seg_q;
				result_q   <= rd_value_q;  // empty or reversed segment gives the later key
			end
			ST_FRAC_WAIT: if (div_ctl.done) frac_q <= frac_sat;
			ST_MUL: prod_q <= diff_q * frac_q;
			ST_CLAMP: begin
				if (vsum > 67'sh7FFF_FFFF) result_q <= 32'sh7FFF_FFFF;
				else if (vsum < -67'sh8000_0000) result_q <= 32'sh8000_0000;
				else result_q <= vsum[31:0];
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid_q |-> !in_ready)
		else $error("input taken while a result waits");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.busy |-> (state_q == ST_WRAP_WAIT || state_q == ST_FRAC_WAIT))
		else $error("divider busy outside a wait state");
	assert property (@(posedge clk) disable iff (!arst_n) state_q == ST_OUT |=> out_valid_q)
		else $error("result not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && accept_in && action && n_eff < CountW'(2)) |=> state_q == ST_OUT)
		else $error("short table did not skip search");
endmodule

// ===== rtl/kcs_divider.sv =====
// Restoring unsigned divider, 64-bit dividend by 33-bit divisor, one quotient bit a cycle.
// Depends on kcs_pkg for the control struct.
`timescale 1ns / 1ps
module kcs_divider
	import kcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [32:0] divisor,
	output div_ctl_t    ctl,
	output logic [63:0] quotient,
	output logic [32:0] remainder
);
	logic [6:0]  count_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] quo_q;
	logic [33:0] rem_q;
	logic [32:0] div_q;
	logic [33:0] trial;
	logic [33:0] shifted;

	// Shift in the next dividend bit and try a subtract.
	assign shifted = {rem_q[32:0], quo_q[63]};
	assign trial   = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= 7'd64;
			end else if (busy_q) begin
				count_q <= count_q - 7'd1;
				if (count_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q[32:0];
	assign ctl       = '{start: start, busy: busy_q, done: done_q};

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> count_q != 7'd0)
		else $error("divider count underflow");
endmodule

// ===== test/kcs_checker.sv =====
// Scoreboard for the keyframe curve sampler: watches the item, result and register channels,
// keeps its own keyframe tables and predicts every sample. Depends on kcs_pkg.
`timescale 1ns / 1ps
module kcs_checker
	import kcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               action,
	input  logic [5:0]         key_index,
	input  logic [31:0]        key_time,
	input  logic signed [31:0] key_value,
	input  logic [31:0]        sample_time,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] sample_value,
	input  logic [5:0]         segment_used,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 errors,
	output int                 pending,
	output int                 checked
);
	typedef struct {
		logic signed [31:0] value;
		logic [5:0]         segment;
	} curve_point_t;

	curve_point_t expected_points[$];

	logic [31:0]        time_table[MaxKeys];
	logic signed [31:0] value_table[MaxKeys];
	logic [5:0]         seg_hint;
	logic [6:0]         key_count;
	logic               loop_on;
	logic [31:0]        loop_len;

	function automatic longint floor_div(longint num, longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	// Hint first, then binary search; unsorted tables end at min(lo, n-2).
	function automatic int find_segment(logic [31:0] tw, int n);
		int top_seg;
		int h;
		int lo;
		int hi;
		int mid;
		top_seg = n - 2;
		h = seg_hint;
		lo = 0;
		hi = top_seg;
		if (h > top_seg)
			h = top_seg;
		if (time_table[h] <= tw && tw <= time_table[h + 1])
			return h;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (time_table[mid] <= tw) begin
				if (tw <= time_table[mid + 1])
					return mid;
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		if (lo > top_seg)
			lo = top_seg;
		return lo;
	endfunction

	function automatic curve_point_t evaluate_curve(logic [31:0] t_in);
		curve_point_t p;
		int n;
		int seg;
		logic [31:0] tw;
		longint span;
		longint frac;
		longint diff;
		longint v;
		n = (key_count > MaxKeys) ? MaxKeys : key_count;
		p.value = '0;
		p.segment = '0;
		if (n == 0)
			return p;
		if (n == 1) begin
			p.value = value_table[0];
			return p;
		end
		tw = t_in;
		if (loop_on && loop_len != 0)
			tw = tw % loop_len;
		seg = find_segment(tw, n);
		seg_hint = seg[5:0];
		span = longint'(time_table[seg + 1]) - longint'(time_table[seg]);
		if (span <= 0) begin
			v = longint'(value_table[seg + 1]);
		end else begin
			frac = sat32(floor_div((longint'(tw) - longint'(time_table[seg])) * 65536, span));
			diff = longint'(value_table[seg + 1]) - longint'(value_table[seg]);
			v = sat32(longint'(value_table[seg]) + floor_div(diff * frac, 65536));
		end
		p.value = v[31:0];
		p.segment = seg[5:0];
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		curve_point_t got;
		curve_point_t want;
		if (!arst_n) begin
			seg_hint = '0;
			key_count = '0;
			loop_on = 1'b0;
			loop_len = '0;
			errors = 0;
			pending = 0;
			checked = 0;
			expected_points.delete();
			foreach (time_table[i]) begin
				time_table[i] = '0;
				value_table[i] = '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_index_t'(cfg_index))
					REG_KEY_COUNT:   key_count = cfg_data[6:0];
					REG_LOOP_ENABLE: loop_on = cfg_data[0];
					REG_LOOP_LENGTH: loop_len = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got.value = sample_value;
				got.segment = segment_used;
				checked++;
				if (expected_points.size() == 0) begin
					$error("result with no sample waiting: value %0d segment %0d",
						got.value, got.segment);
					errors++;
				end else begin
					want = expected_points.pop_front();
					if (got.value !== want.value) begin
						$error("sample_value: expected %0d, actual %0d", want.value, got.value);
						errors++;
					end
					if (got.segment !== want.segment) begin
						$error("segment_used: expected %0d, actual %0d",
							want.segment, got.segment);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (action) begin
					expected_points.push_back(evaluate_curve(sample_time));
				end else begin
					time_table[key_index] = key_time;
					value_table[key_index] = key_value;
				end
			end
			pending = expected_points.size();
		end
	end
endmodule

// ===== test/keyframe_curve_sampler_tb.sv =====
// Top of the keyframe curve sampler testbench: clock, reset, stimulus and verdict.
// Depends on kcs_pkg, keyframe_curve_sampler and kcs_checker.
`timescale 1ns / 1ps
module keyframe_curve_sampler_tb;
	import kcs_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               action;
	logic [5:0]         key_index;
	logic [31:0]        key_time;
	logic signed [31:0] key_value;
	logic [31:0]        sample_time;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] sample_value;
	logic [5:0]         segment_used;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;

	int errors;
	int pending;
	int checked;

	// Random idling on both channels is switched off for a stretch of phases.
	bit idle_on;
	// Toggling this asks the receiver to hold off out_ready for a long stretch.
	bit stall_req;
	int items_sent;
	int samples_sent;

	// Key times as loaded, so that sample times can be aimed at the segments.
	logic [31:0] key_times_now[MaxKeys];
	int keys_in_use;

	keyframe_curve_sampler i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .key_index(key_index), .key_time(key_time),
		.key_value(key_value), .sample_time(sample_time),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample_value(sample_value), .segment_used(segment_used),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	kcs_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .key_index(key_index), .key_time(key_time),
		.key_value(key_value), .sample_time(sample_time),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample_value(sample_value), .segment_used(segment_used),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .checked(checked)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Generous run limit; a correct run needs only a few milliseconds.
	initial begin
		#60ms;
		$display("FAIL keyframe_curve_sampler");
		$finish;
	end

	// Receiver: random back-pressure, plus one long hold-off per request. The
	// hold is counted here so the sender keeps offering items while it lasts.
	initial begin
		bit seen_req;
		int hold_left;
		seen_req = 1'b0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_req != seen_req) begin
				seen_req = stall_req;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(idle_on && $urandom_range(99) < 16);
			end
		end
	end

	// Offer one item and wait for it to be taken. The valid is never dropped
	// and raised in the same step: an idle gap lowers it and lets a cycle pass.
	task automatic offer_item(bit is_sample, logic [5:0] idx, logic [31:0] kt,
		logic [31:0] kv, logic [31:0] st);
		while (idle_on && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= is_sample;
		key_index <= idx;
		key_time <= kt;
		key_value <= kv;
		sample_time <= st;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		if (is_sample)
			samples_sent++;
		else
			key_times_now[idx] = kt;
	endtask

	task automatic write_key(logic [5:0] idx, logic [31:0] kt, logic [31:0] kv);
		offer_item(1'b0, idx, kt, kv, $urandom);
	endtask

	task automatic sample_at(logic [31:0] st);
		offer_item(1'b1, $urandom, $urandom, $urandom, st);
	endtask

	// Stop offering and wait until every predicted result has come back, then wait on
	// a little so that a trailing key write has surely landed.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Load keys 0..n-1. Most curves are sorted with random gaps; some carry
	// repeated times (zero-length segments) and a few are plain unsorted noise.
	task automatic load_curve(int n);
		int shape;
		longint t;
		longint step_max;
		logic [31:0] kv;
		shape = $urandom_range(9);
		t = (shape < 3) ? longint'($urandom_range(1000)) : longint'($urandom);
		step_max = (longint'(32'hFFFF_FFFF) - t) / (n > 0 ? n : 1);
		if (shape >= 6 && step_max > 5000)
			step_max = 5000;
		for (int i = 0; i < n; i++) begin
			kv = ($urandom_range(3) == 0) ? $urandom_range(65536 * 8) : $urandom;
			if (shape == 9)
				write_key(i, $urandom, kv);
			else
				write_key(i, t[31:0], kv);
			if (!(shape == 5 && $urandom_range(3) == 0))
				t = t + longint'($urandom_range(0, 32'hFFFF_FFFF)) % (step_max + 1);
		end
		keys_in_use = n;
	endtask

	// Sample times aimed at keys, inside segments, outside the key range and
	// at the ends of the 32-bit range.
	function automatic logic [31:0] pick_time();
		int k;
		k = (keys_in_use > 0) ? $urandom_range(keys_in_use - 1) : 0;
		case ($urandom_range(7))
			0: return key_times_now[k];
			1: return key_times_now[k] + $urandom_range(3) - 1;
			2, 3: return key_times_now[k] + $urandom_range(4000);
			4: return 32'h0000_0000;
			5: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int n;
		int phase;
		int burst;
		logic [31:0] len;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = 1'b0;
		key_index = '0;
		key_time = '0;
		key_value = '0;
		sample_time = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_KEY_COUNT;
		cfg_data = '0;
		idle_on = 1'b1;
		stall_req = 1'b0;
		items_sent = 0;
		samples_sent = 0;
		keys_in_use = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, single key, a zero-length segment, extreme
		// values, extrapolation far on both sides and the loop settings.
		sample_at(32'h1234_5678);
		write_key(0, 100, 32'h8000_0000);
		wait_idle();
		write_reg(REG_KEY_COUNT, 1);
		sample_at(32'hFFFF_FFFF);
		write_key(1, 100, 32'h0001_0000);
		write_key(2, 300, 32'h7FFF_FFFF);
		write_key(3, 32'hFFFF_FF00, 32'h8000_0000);
		write_key(63, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		wait_idle();
		keys_in_use = 4;
		write_reg(REG_KEY_COUNT, 4);
		sample_at(0);
		sample_at(100);
		sample_at(200);
		sample_at(300);
		sample_at(32'h8000_0000);
		sample_at(32'hFFFF_FFFF);
		wait_idle();
		write_reg(REG_LOOP_ENABLE, 1);
		sample_at(32'hFFFF_FFFF);
		wait_idle();
		write_reg(REG_LOOP_LENGTH, 250);
		sample_at(32'hFFFF_FFFF);
		sample_at(249);
		wait_idle();
		write_reg(REG_LOOP_LENGTH, 32'hFFFF_FFFF);
		sample_at(32'hFFFF_FFFE);
		sample_at(32'hFFFF_FFFF);
		wait_idle();
		write_reg(REG_LOOP_ENABLE, 0);

		// Random phases: load a curve, set the registers, then a burst of
		// samples with the odd key rewrite mixed in.
		phase = 0;
		while (items_sent < 950) begin
			idle_on = !(phase >= 6 && phase < 14);
			case ($urandom_range(19))
				0: n = 0;
				1: n = 1;
				2, 3: n = MaxKeys;
				default: n = $urandom_range(2, 12);
			endcase
			load_curve(n == 0 ? 1 : n);
			wait_idle();
			write_reg(REG_KEY_COUNT, n);
			write_reg(REG_LOOP_ENABLE, $urandom_range(1));
			case ($urandom_range(5))
				0: len = 0;
				1: len = 1;
				2: len = 32'hFFFF_FFFF;
				3: len = key_times_now[keys_in_use - 1] + $urandom_range(2000);
				default: len = $urandom;
			endcase
			write_reg(REG_LOOP_LENGTH, len);
			// Once, the receiver holds off while samples keep coming.
			if (phase == 3)
				stall_req = !stall_req;
			burst = $urandom_range(10, 30);
			for (int i = 0; i < burst; i++) begin
				if ($urandom_range(9) == 0)
					write_key($urandom_range(keys_in_use - 1), pick_time(), $urandom);
				else
					sample_at(pick_time());
			end
			wait_idle();
			phase++;
		end

		wait_idle();
		repeat (200) @(posedge clk);
		$display("Ran %0d items over %0d curve setups; %0d samples checked.",
			items_sent, phase, checked);
		if (errors == 0 && pending == 0)
			$display("PASS keyframe_curve_sampler");
		else
			$display("FAIL keyframe_curve_sampler");
		$finish;
	end
endmodule
